### rtl/core/cst_pkg.sv
// ============================================================================
// cst_pkg: shared types and codes for the compacting set table
// Request and result payloads, action and status codes, cell control group.
// ============================================================================
`default_nettype none

package cst_pkg;

  // Default sizing of the table.
  localparam int MAX_ENTRIES_DEF = 16;
  localparam int VALUE_BITS_DEF  = 16;

  // Fixed field widths of the request and result payloads.
  localparam int ACTION_W = 2;
  localparam int VALUE_W  = 16;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // Action codes.
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NO_CHANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL      = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [VALUE_W-1:0]  value;
  } cst_in_t;

  typedef struct packed {
    logic                was_member;
    logic [COUNT_W-1:0]  count;
    logic                is_empty;
    logic                is_full;
    logic [STATUS_W-1:0] status;
  } cst_out_t;

  // Control group broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;    // capture the per-cell match
    logic shift_en;  // delete: the matching cell and those past it take their neighbor's entry
    logic write_en;  // insert: the first free cell takes the value if absent
  } cst_cell_ctl_t;

endpackage

`default_nettype wire

### rtl/core/compacting_set_table.sv
// ============================================================================
// compacting_set_table: packed set of distinct values with a count
// Query, insert, delete with compaction, and clear over a chain of cells.
// ============================================================================
//
//   channel   direction   payload     handshake
//   in_       request     cst_in_t    in_valid / in_stall
//   out_      result      cst_out_t   out_valid / out_stall
//
// Each request has a compare cycle in which every cell checks
// its entry, then an apply cycle in which the match prefix runs down the
// cell chain and entries shift or are written. A new request is taken
// while idle or in the apply cycle of the request before it.
// Reset clears the count and the control state; entries hold no reset.
// A stalled result holds the apply cycle until the output register frees.
// ============================================================================
`default_nettype none

module compacting_set_table #(
  parameter int MAX_ENTRIES = cst_pkg::MAX_ENTRIES_DEF,
  parameter int VALUE_BITS  = cst_pkg::VALUE_BITS_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire cst_pkg::cst_in_t  in_data,
  output logic                   out_valid,
  input  wire                    out_stall,
  output cst_pkg::cst_out_t      out_data
);
  import cst_pkg::*;

  localparam int CNT_BITS = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_MATCH = 3'b010,
    ST_APPLY = 3'b100
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic [ACTION_W-1:0]   action_r;
  logic [VALUE_BITS-1:0] value_r;
  logic                  out_valid_r, out_valid_nxt;
  cst_out_t              out_data_r;
  cst_out_t              result;
  logic                  in_take;
  logic                  can_apply;
  logic                  do_apply;
  logic                  member;
  cst_cell_ctl_t         cell_ctl;

  logic [VALUE_BITS-1:0] entry_w  [MAX_ENTRIES];
  logic                  prefix_w [MAX_ENTRIES+1];

  // Handshake decisions.
  assign can_apply = !out_valid_r || !out_stall;
  assign do_apply  = (state_r == ST_APPLY) && can_apply;
  assign in_stall  = !((state_r == ST_IDLE) || do_apply);
  assign in_take   = in_valid && !in_stall;

  // Cell control broadcast.
  assign cell_ctl.cmp_en   = state_r == ST_MATCH;
  assign cell_ctl.shift_en = do_apply && (action_r == ACT_DELETE);
  assign cell_ctl.write_en = do_apply && (action_r == ACT_INSERT);

  // Chain of cells; the match prefix enters at slot zero.
  assign prefix_w[0] = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [VALUE_BITS-1:0] upper;
    if (i + 1 < MAX_ENTRIES) begin : g_mid
      assign upper = entry_w[i+1];
    end else begin : g_top
      assign upper = entry_w[i];
    end
    cst_cell #(
      .VALUE_BITS (VALUE_BITS),
      .CNT_BITS   (CNT_BITS),
      .CELL_IDX   (i)
    ) u_cell (
      .clk         (clk),
      .ctl         (cell_ctl),
      .count       (count_r),
      .value       (value_r),
      .upper_entry (upper),
      .prefix_in   (prefix_w[i]),
      .prefix_out  (prefix_w[i+1]),
      .entry       (entry_w[i])
    );
  end

  assign member = prefix_w[MAX_ENTRIES];

  // Count update and result for the request in its apply cycle.
  always_comb begin
    count_nxt       = count_r;
    result.status   = STAT_DONE;
    unique case (action_r)
      ACT_INSERT: begin
        if (member) begin
          result.status = STAT_NO_CHANGE;
        end else if (count_r == CNT_BITS'(MAX_ENTRIES)) begin
          result.status = STAT_FULL;
        end else begin
          count_nxt = count_r + CNT_BITS'(1);
        end
      end
      ACT_DELETE: begin
        if (!member) begin
          result.status = STAT_NO_CHANGE;
        end else begin
          count_nxt = count_r - CNT_BITS'(1);
        end
      end
      ACT_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    result.was_member = member;
    result.count      = COUNT_W'(count_nxt);
    result.is_empty   = count_nxt == '0;
    result.is_full    = count_nxt == CNT_BITS'(MAX_ENTRIES);
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) state_nxt = ST_MATCH;
      end
      ST_MATCH: begin
        state_nxt = ST_APPLY;
      end
      ST_APPLY: begin
        if (do_apply) state_nxt = in_take ? ST_MATCH : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (do_apply) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (do_apply) count_r <= count_nxt;
    end
  end

  // Request capture and result payload.
  always_ff @(posedge clk) begin
    if (in_take) begin
      action_r <= in_data.action;
      value_r  <= VALUE_BITS'(in_data.value);
    end
    if (do_apply) out_data_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### rtl/core/cst_cell.sv
// ============================================================================
// cst_cell: one slot of the compacting set table
// Holds one entry, compares it with the request value and passes the
// match prefix and its entry on to the neighboring cells.
// ============================================================================
`default_nettype none

module cst_cell #(
  parameter int VALUE_BITS = cst_pkg::VALUE_BITS_DEF,
  parameter int CNT_BITS   = 5,
  parameter int CELL_IDX   = 0
) (
  input  wire                       clk,
  input  wire cst_pkg::cst_cell_ctl_t ctl,
  input  wire [CNT_BITS-1:0]        count,
  input  wire [VALUE_BITS-1:0]      value,
  input  wire [VALUE_BITS-1:0]      upper_entry,
  input  wire                       prefix_in,
  output logic                      prefix_out,
  output logic [VALUE_BITS-1:0]     entry
);
  import cst_pkg::*;

  logic [VALUE_BITS-1:0] entry_r;
  logic [VALUE_BITS-1:0] entry_nxt;
  logic                  hit_r;
  logic                  hit_nxt;
  logic                  occupied;
  logic                  has_upper;
  logic                  is_free_slot;

  // Slot occupancy follows from the shared count.
  assign occupied     = count > CNT_BITS'(CELL_IDX);
  assign has_upper    = count > CNT_BITS'(CELL_IDX + 1);
  assign is_free_slot = count == CNT_BITS'(CELL_IDX);

  // A match at or below this cell marks it as part of the compaction run.
  assign prefix_out = prefix_in | hit_r;

  // Compare phase captures the match; apply phase shifts or writes.
  always_comb begin
    hit_nxt   = hit_r;
    entry_nxt = entry_r;
    if (ctl.cmp_en) begin
      hit_nxt = occupied && (entry_r == value);
    end
    if (ctl.shift_en && prefix_out && has_upper) begin
      entry_nxt = upper_entry;
    end
    // Below the first free slot no match means the value is absent.
    if (ctl.write_en && is_free_slot && !prefix_in) begin
      entry_nxt = value;
    end
  end

  always_ff @(posedge clk) begin
    hit_r   <= hit_nxt;
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

`default_nettype wire

### verif/tb_compacting_set_table.sv
// ============================================================================
// tb_compacting_set_table: self-checking bench for the compacting set table
// Drives query, insert, delete and clear requests through the valid/stall
// channels and checks every result against a shadow copy of the set or a typed-in expectation.
// ============================================================================
`timescale 1ns / 100ps

module tb_compacting_set_table;
  import cst_pkg::*;

  localparam int RANDOM_ITEMS   = 1250;
  localparam int TAIL_ITEMS     = 150;
  localparam int HOLD_AT        = 400;
  localparam int DRAIN_AT       = 800;
  localparam int LONG_HOLD      = 80;
  localparam int POOL_SIZE      = 24;
  localparam int WATCHDOG_LIMIT = 2000;

  // One row of the directed table; the expected result is typed in when known.
  typedef struct {
    cst_in_t  req;
    bit       typed;
    cst_out_t want;
  } dir_row_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  cst_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  cst_out_t out_data;

  // Shadow copy of the set kept by the predictor.
  logic [VALUE_W-1:0] shadow_vals [MAX_ENTRIES_DEF];
  int                 shadow_size;

  cst_out_t   pending_results[$];
  dir_row_t   dir_rows[$];
  logic [VALUE_W-1:0] value_pool[POOL_SIZE];

  int  err_count     = 0;
  int  quiet_cycles  = 0;
  int  action_seen[4];
  int  full_rejects  = 0;
  int  peak_size     = 0;
  bit  send_idle_on  = 1'b1;
  bit  stall_idle_on = 1'b1;
  bit  hold_req      = 1'b0;

  compacting_set_table dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one request to the shadow set and returns the result it should give.
  function automatic cst_out_t apply_set_action(cst_in_t req);
    cst_out_t res;
    bit       hit;
    int       pos;
    hit = 1'b0;
    pos = 0;
    res = '0;
    res.status = STAT_DONE;
    for (int i = 0; i < shadow_size; i++) begin
      if (!hit && shadow_vals[i] == req.value) begin
        hit = 1'b1;
        pos = i;
      end
    end
    case (req.action)
      ACT_INSERT: begin
        if (hit) begin
          res.status = STAT_NO_CHANGE;
        end else if (shadow_size >= MAX_ENTRIES_DEF) begin
          res.status = STAT_FULL;
        end else begin
          shadow_vals[shadow_size] = req.value;
          shadow_size++;
        end
      end
      ACT_DELETE: begin
        if (!hit) begin
          res.status = STAT_NO_CHANGE;
        end else begin
          // Later entries slide down one slot to keep the array packed.
          for (int i = pos; i + 1 < shadow_size; i++) shadow_vals[i] = shadow_vals[i + 1];
          shadow_size--;
        end
      end
      ACT_CLEAR: begin
        shadow_size = 0;
      end
      default: begin
      end
    endcase
    res.was_member = hit;
    res.count      = shadow_size[COUNT_W-1:0];
    res.is_empty   = (shadow_size == 0);
    res.is_full    = (shadow_size == MAX_ENTRIES_DEF);
    return res;
  endfunction

  function automatic cst_out_t mk_out(logic wm, logic [COUNT_W-1:0] cnt, logic emp,
                                      logic ful, logic [STATUS_W-1:0] st);
    cst_out_t res;
    res.was_member = wm;
    res.count      = cnt;
    res.is_empty   = emp;
    res.is_full    = ful;
    res.status     = st;
    return res;
  endfunction

  task automatic add_row(logic [ACTION_W-1:0] act, logic [VALUE_W-1:0] val, bit typed,
                         cst_out_t want);
    dir_row_t row;
    row.req.action = act;
    row.req.value  = val;
    row.typed      = typed;
    row.want       = want;
    dir_rows.push_back(row);
  endtask

  // Offers one request, waits for the handshake, then records its expected result.
  // The valid stays high afterwards; the caller lowers it when it idles.
  task automatic send_request(cst_in_t req, bit typed, cst_out_t want);
    cst_out_t pred;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    pred = apply_set_action(req);
    pending_results.push_back(typed ? want : pred);
    action_seen[req.action]++;
    if (pred.status == STAT_FULL) full_rejects++;
    if (shadow_size > peak_size) peak_size = shadow_size;
  endtask

  // Sender idle burst between requests.
  task automatic maybe_idle_sender();
    if (send_idle_on && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Result checker: every accepted result is compared with the oldest expectation.
  always @(posedge clk) begin
    cst_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding: %p", out_data);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.was_member !== want.was_member) begin
          $error("was_member: expected %0d, got %0d", want.was_member, out_data.was_member);
          err_count++;
        end
        if (out_data.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_data.count);
          err_count++;
        end
        if (out_data.is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, out_data.is_empty);
          err_count++;
        end
        if (out_data.is_full !== want.is_full) begin
          $error("is_full: expected %0d, got %0d", want.is_full, out_data.is_full);
          err_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          err_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a request or result.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (stall_idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Main sequence: reset, directed table, random traffic, drain and report.
  initial begin
    cst_in_t req;
    int      r;

    for (int a = 0; a < 4; a++) action_seen[a] = 0;
    shadow_size = 0;
    for (int i = 0; i < MAX_ENTRIES_DEF; i++) shadow_vals[i] = '0;

    // Value pool keeps hits frequent; the two extremes are always in it.
    value_pool[0] = 16'h0000;
    value_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) value_pool[i] = VALUE_W'($urandom_range(0, 16'hFFFF));

    // Directed table: empty set, duplicates, filling up, full rejection,
    // compaction from the head and the tail, and clear.
    add_row(ACT_QUERY,  16'h0000, 1, mk_out(0, 0, 1, 0, STAT_DONE));
    add_row(ACT_DELETE, 16'hFFFF, 1, mk_out(0, 0, 1, 0, STAT_NO_CHANGE));
    add_row(ACT_INSERT, 16'h0000, 1, mk_out(0, 1, 0, 0, STAT_DONE));
    add_row(ACT_INSERT, 16'h0000, 1, mk_out(1, 1, 0, 0, STAT_NO_CHANGE));
    add_row(ACT_DELETE, 16'h1234, 1, mk_out(0, 1, 0, 0, STAT_NO_CHANGE));
    add_row(ACT_INSERT, 16'hFFFF, 0, '0);
    for (int k = 0; k < 14; k++) add_row(ACT_INSERT, 16'h0001 << k, 0, '0);
    add_row(ACT_INSERT, 16'hAAAA, 1, mk_out(0, 16, 0, 1, STAT_FULL));
    add_row(ACT_INSERT, 16'hFFFF, 1, mk_out(1, 16, 0, 1, STAT_NO_CHANGE));
    add_row(ACT_DELETE, 16'h0000, 0, '0);
    add_row(ACT_DELETE, 16'h2000, 0, '0);
    add_row(ACT_QUERY,  16'h0000, 0, '0);
    add_row(ACT_CLEAR,  16'hFFFF, 1, mk_out(1, 0, 1, 0, STAT_DONE));
    add_row(ACT_QUERY,  16'hFFFF, 1, mk_out(0, 0, 1, 0, STAT_DONE));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      maybe_idle_sender();
    end

    // Random traffic, mostly over the pool so the set fills and empties.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - TAIL_ITEMS) begin
        send_idle_on  = 1'b0;
        stall_idle_on = 1'b0;
      end
      if (n == HOLD_AT) hold_req = 1'b1;
      if (n == DRAIN_AT) begin
        // Sender pauses until every outstanding result has come back.
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
      end
      maybe_idle_sender();

      r = $urandom_range(0, 99);
      if (r < 3) begin
        req.action = ACT_CLEAR;
      end else if (r < 23) begin
        req.action = ACT_QUERY;
      end else if (r < 65) begin
        req.action = ACT_INSERT;
      end else begin
        req.action = ACT_DELETE;
      end
      if ($urandom_range(0, 99) < 85) begin
        req.value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else begin
        req.value = VALUE_W'($urandom_range(0, 16'hFFFF));
      end
      send_request(req, 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain, then keep the clock running for any stray result.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d queries, %0d inserts, %0d deletes, %0d clears.",
             action_seen[ACT_QUERY], action_seen[ACT_INSERT],
             action_seen[ACT_DELETE], action_seen[ACT_CLEAR]);
    $display("Inserts rejected on a full set: %0d; largest set size seen: %0d.",
             full_rejects, peak_size);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### compacting_set_table.f
rtl/core/cst_pkg.sv
rtl/core/cst_cell.sv
rtl/core/compacting_set_table.sv
verif/tb_compacting_set_table.sv
